// ----- rtl/u8d_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// No dependencies; every other file of the decoder imports this package.
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int REM_W  = 2;

    // Lead byte classification masks and match values.
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_VAL  = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [REM_W-1:0] bytes_remaining;
        logic [CP_W-1:0]  accumulator;
        logic             discarding;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            stream_done;
    } dec_result_t;

endpackage

// ----- rtl/u8d_step.sv -----
// Combinational decode step: one byte plus the current decoder state gives the
// next state and at most one result word. Depends on u8d_pkg.
module u8d_step (
    input  logic [7:0]          in_byte,
    input  logic                end_of_stream,
    input  u8d_pkg::dec_state_t state_cur,
    output u8d_pkg::dec_state_t state_nxt,
    output logic                res_valid,
    output u8d_pkg::dec_result_t res
);
    import u8d_pkg::*;

    always_comb
    begin
        logic [CP_W-1:0]  acc_shift;
        logic [REM_W-1:0] rem_dec;

        acc_shift = {state_cur.accumulator[CP_W-7:0], in_byte[5:0]};
        rem_dec   = state_cur.bytes_remaining - REM_W'(1);

        state_nxt       = state_cur;
        res_valid       = 1'b0;
        res.code_point  = '0;
        res.status      = ST_OK;
        res.stream_done = 1'b0;

        priority if (state_cur.discarding)
        begin
            res_valid = 1'b0;
        end
        else if (state_cur.bytes_remaining != '0)
        begin
            // Continuation byte; its top two bits are not checked.
            state_nxt.accumulator     = acc_shift;
            state_nxt.bytes_remaining = rem_dec;
            if (rem_dec == '0)
            begin
                res_valid       = 1'b1;
                res.code_point  = acc_shift;
                res.stream_done = end_of_stream;
            end
            else if (end_of_stream)
            begin
                res_valid       = 1'b1;
                res.status      = ST_TRUNCATED;
                res.stream_done = 1'b1;
            end
        end
        else if ((in_byte & ASCII_MASK) == ASCII_VAL)
        begin
            res_valid       = 1'b1;
            res.code_point  = CP_W'(in_byte);
            res.stream_done = end_of_stream;
        end
        else if ((in_byte & LEAD2_MASK) == LEAD2_VAL ||
                 (in_byte & LEAD3_MASK) == LEAD3_VAL ||
                 (in_byte & LEAD4_MASK) == LEAD4_VAL)
        begin
            priority if ((in_byte & LEAD2_MASK) == LEAD2_VAL)
            begin
                state_nxt.accumulator     = CP_W'(in_byte[4:0]);
                state_nxt.bytes_remaining = REM_W'(1);
            end
            else if ((in_byte & LEAD3_MASK) == LEAD3_VAL)
            begin
                state_nxt.accumulator     = CP_W'(in_byte[3:0]);
                state_nxt.bytes_remaining = REM_W'(2);
            end
            else
            begin
                state_nxt.accumulator     = CP_W'(in_byte[2:0]);
                state_nxt.bytes_remaining = REM_W'(3);
            end
            if (end_of_stream)
            begin
                res_valid       = 1'b1;
                res.status      = ST_TRUNCATED;
                res.stream_done = 1'b1;
            end
        end
        else
        begin
            res_valid            = 1'b1;
            res.status           = ST_BAD_LEAD;
            res.stream_done      = 1'b1;
            state_nxt.discarding = 1'b1;
        end

        // The end of a stream always returns the decoder to its reset state.
        if (end_of_stream)
        begin
            state_nxt = '0;
        end
    end

endmodule

// ----- rtl/u8d_out_fifo.sv -----
// Two-entry output buffer with a registered head; it keeps the result side
// from stalling the input side unless both entries are full. Depends on u8d_pkg.
module u8d_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u8d_pkg::dec_result_t din,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8d_pkg::dec_result_t dout,
    output logic [1:0]           count
);
    import u8d_pkg::*;

    logic [1:0]  count_reg, count_next;
    dec_result_t head_reg, head_next;
    dec_result_t tail_reg, tail_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign dout      = head_reg;
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        unique case ({push, pop})
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = din;
                end
                else
                begin
                    tail_next = din;
                end
                count_next = count_reg + 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = din;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = din;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- rtl/utf8_to_utf32_decoder.sv -----
// UTF-8 to UTF-32 streaming decoder, top level. Uses u8d_pkg, u8d_step, u8d_out_fifo.
// Each byte is registered in the input stage and its result word in the output buffer.
// Throughput: one byte per cycle while the output buffer has space; the decode step is
// one pass of mask-and-shift logic between the input register and the two-entry buffer.
// Reset (rst_n, asynchronous, active low) empties both stages and clears the decoder
// state: no pending sequence, zero accumulator, not discarding.
module utf8_to_utf32_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // Slave side: one UTF-8 byte per word.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_stream
    // Master side: one decoded result per word.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // stream_done
);
    import u8d_pkg::*;

    // Input stage: one byte waiting to be decoded.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // Decoder state, updated when the held byte is consumed.
    dec_state_t state_reg, state_next;
    dec_state_t step_state;

    dec_result_t step_res;
    dec_result_t fifo_dout;
    logic        step_res_valid;
    logic        fifo_space;
    logic        fifo_push;
    logic [1:0]  fifo_count;
    logic        advance;
    logic        s_accept;

    u8d_step u_step (
        .in_byte       (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .state_cur     (state_reg),
        .state_nxt     (step_state),
        .res_valid     (step_res_valid),
        .res           (step_res)
    );

    // The held byte moves on unless it has a result and the buffer is full.
    // The buffer's fullness is registered, so m_axis_tready never reaches
    // s_axis_tready through logic.
    assign advance       = in_valid_reg && (!step_res_valid || fifo_space);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign fifo_push     = advance && step_res_valid;

    u8d_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .din       (step_res),
        .space     (fifo_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dout      (fifo_dout),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {3'b000, fifo_dout.code_point};
    assign m_axis_tuser = fifo_dout.status;
    assign m_axis_tlast = fifo_dout.stream_done;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        state_next = advance ? step_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

`ifndef SYNTHESIS
    // Discarding only starts from an idle sequence and never alongside one.
    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.discarding |-> (state_reg.bytes_remaining == '0))
        else $error("discarding while a sequence is pending");

    // Consuming the last byte of a stream leaves the decoder fully cleared.
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eos_reg) |=> (state_reg == '0))
        else $error("state not cleared after end of stream");

    // The output buffer is never pushed while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_count != 2'd2))
        else $error("push into a full output buffer");

    // Error results carry a zero code point and end the stream.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_push && (step_res.status != ST_OK)) |->
            (step_res.stream_done && (step_res.code_point == '0)))
        else $error("malformed error result");

    // No result is produced while bytes are being dropped.
    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && state_reg.discarding) |-> !step_res_valid)
        else $error("result produced while discarding");
`endif

endmodule

// ----- sim/utf8_to_utf32_decoder_tb.sv -----
// Self-checking testbench for the UTF-8 to UTF-32 streaming decoder.
// Depends on rtl/u8d_pkg.sv and the decoder RTL under rtl/ (top level, step, output buffer).
// Bytes go in on the slave side, and each result word is checked against a local decoder.
module utf8_to_utf32_decoder_tb;

    import u8d_pkg::*;

    // A run of this many cycles in which no word moves on either side counts as a hang.
    localparam int unsigned HANG_LIMIT = 2000;

    // Opening byte list, {end_of_stream, in_byte}: ASCII extremes, the smallest and
    // largest two-byte and the largest four-byte sequence, continuations with wrong
    // top bits, truncation on a continuation and on a lead, and bad leads that are
    // followed by discarded bytes or that fall on the last byte of a stream.
    localparam logic [8:0] OPENING_BYTES [0:22] = '{
        9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h1BF,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h0E1, 9'h0FF, 9'h040,
        9'h0E2, 9'h182,
        9'h1F0,
        9'h080, 9'h041, 9'h1C2,
        9'h1FF,
        9'h0F8, 9'h17F,
        9'h141
    };

    // The scoreboard keeps its own copy of the decoder state. Every accepted byte
    // is decoded here, and any word that it yields waits in a queue until the block
    // hands out the matching result word.
    class decode_scoreboard;
        dec_result_t      expected_words[$];
        logic [REM_W-1:0] seq_left;
        logic [CP_W-1:0]  cp_acc;
        logic             dropping;
        int unsigned      errors;

        function new();
            seq_left = '0;
            cp_acc   = '0;
            dropping = 1'b0;
            errors   = 0;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic eos);
            dec_result_t r;
            bit          emit;
            r    = '0;
            emit = 1'b0;
            if (dropping)
            begin
                // Everything after a bad lead is dropped until the stream ends.
            end
            else if (seq_left != 0)
            begin
                // Any byte counts as a continuation; its top bits are not looked at.
                cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == 0)
                begin
                    r.code_point  = cp_acc;
                    r.status      = ST_OK;
                    r.stream_done = eos;
                    emit          = 1'b1;
                end
                else if (eos)
                begin
                    r.status      = ST_TRUNCATED;
                    r.stream_done = 1'b1;
                    emit          = 1'b1;
                end
            end
            else if ((b & ASCII_MASK) == ASCII_VAL)
            begin
                r.code_point  = CP_W'(b);
                r.status      = ST_OK;
                r.stream_done = eos;
                emit          = 1'b1;
            end
            else if ((b & LEAD2_MASK) == LEAD2_VAL || (b & LEAD3_MASK) == LEAD3_VAL
                     || (b & LEAD4_MASK) == LEAD4_VAL)
            begin
                if ((b & LEAD2_MASK) == LEAD2_VAL)
                begin
                    cp_acc   = CP_W'(b[4:0]);
                    seq_left = 2'd1;
                end
                else if ((b & LEAD3_MASK) == LEAD3_VAL)
                begin
                    cp_acc   = CP_W'(b[3:0]);
                    seq_left = 2'd2;
                end
                else
                begin
                    cp_acc   = CP_W'(b[2:0]);
                    seq_left = 2'd3;
                end
                if (eos)
                begin
                    r.status      = ST_TRUNCATED;
                    r.stream_done = 1'b1;
                    emit          = 1'b1;
                end
            end
            else
            begin
                r.status      = ST_BAD_LEAD;
                r.stream_done = 1'b1;
                emit          = 1'b1;
                dropping      = 1'b1;
            end
            if (eos)
            begin
                seq_left = '0;
                cp_acc   = '0;
                dropping = 1'b0;
            end
            if (emit)
                expected_words.push_back(r);
        endfunction

        function void check_word(dec_result_t got);
            dec_result_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word: code_point %0h status %0d stream_done %0b",
                         $time, got.code_point, got.status, got.stream_done);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.code_point !== want.code_point)
            begin
                $display("%0t: code_point mismatch: expected %0h, actual %0h",
                         $time, want.code_point, got.code_point);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.stream_done !== want.stream_done)
            begin
                $display("%0t: stream_done mismatch: expected %0b, actual %0b",
                         $time, want.stream_done, got.stream_done);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    decode_scoreboard sb = new();

    // Percent chances, per cycle, that the sender leaves a gap or the receiver stalls.
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_taken = 0;
    int unsigned quiet_cycles = 0;

    utf8_to_utf32_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // The receiver decides at every falling edge whether to take a word at the next
    // rising edge.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Both handshakes are sampled at the rising edge, before the block's registers
    // move. A byte is decoded first, so that a result word never finds its
    // expectation missing merely because of the order of the two checks.
    always @(posedge clk)
    begin
        dec_result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.code_point  = m_axis_tdata[CP_W-1:0];
                got.status      = status_t'(m_axis_tuser);
                got.stream_done = m_axis_tlast;
                sb.check_word(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offers one byte and returns at the falling edge after it has been taken.
    // tvalid is only lowered during a gap, so it never gets two assignments in one step.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned seen;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        s_axis_tvalid <= 1'b1;
        seen = bytes_taken;
        do
            @(negedge clk);
        while (bytes_taken == seen);
    endtask

    // Holds the sender off until every result word that is owed has come out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Continuation byte carrying six payload bits; now and then its top bits are
    // wrong, which the block must not notice.
    function automatic logic [7:0] cont_byte(logic [5:0] payload);
        logic [1:0] top;
        top = ($urandom_range(9) == 0) ? 2'($urandom) : 2'b10;
        return {top, payload};
    endfunction

    // One random stream. Most characters are well formed with random payload; the
    // rest are bad leads or raw noise, and some streams are cut short inside a
    // multi-byte sequence.
    task automatic send_stream();
        logic [7:0]  stream_bytes[$];
        logic [20:0] payload;
        int unsigned n_chars;
        int unsigned pick;
        n_chars = $urandom_range(8, 1);
        for (int c = 0; c < n_chars; c++)
        begin
            pick    = $urandom_range(99);
            payload = 21'($urandom);
            if (pick < 5)
                stream_bytes.push_back({2'b10, payload[5:0]});
            else if (pick < 8)
                stream_bytes.push_back({5'b11111, payload[2:0]});
            else if (pick < 12)
                stream_bytes.push_back(8'($urandom));
            else if (pick < 40)
                stream_bytes.push_back({1'b0, payload[6:0]});
            else if (pick < 60)
            begin
                stream_bytes.push_back({3'b110, payload[10:6]});
                stream_bytes.push_back(cont_byte(payload[5:0]));
            end
            else if (pick < 80)
            begin
                stream_bytes.push_back({4'b1110, payload[15:12]});
                stream_bytes.push_back(cont_byte(payload[11:6]));
                stream_bytes.push_back(cont_byte(payload[5:0]));
            end
            else
            begin
                stream_bytes.push_back({5'b11110, payload[20:18]});
                stream_bytes.push_back(cont_byte(payload[17:12]));
                stream_bytes.push_back(cont_byte(payload[11:6]));
                stream_bytes.push_back(cont_byte(payload[5:0]));
            end
        end
        if ($urandom_range(5) == 0 && stream_bytes.size() > 1)
            void'(stream_bytes.pop_back());
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    initial
    begin
        int unsigned phase_start;
        bit          held;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (OPENING_BYTES[i])
            send_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);

        // Four idling phases: none, sender gaps, receiver stalls, then both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 54; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 54; end
                default: begin send_gap_pct = 15; stall_pct = 15; end
            endcase
            phase_start = bytes_taken;
            held        = 1'b0;
            while (bytes_taken - phase_start < 450)
            begin
                if (!held && bytes_taken - phase_start >= 225)
                begin
                    hold_until_drained();
                    held = 1'b1;
                end
                send_stream();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
